// ===== design/blsq_pkg.sv =====
`timescale 1ns / 1ps

package blsq_pkg;

  // Default sizing
  parameter int LED_MAX_DEF    = 8;
  parameter int PHASE_BITS_DEF = 10;

  // Breathing step and period limits (ms)
  parameter int STEP_MS   = 20;
  parameter int PERIOD_LO = 500;
  parameter int PERIOD_HI = 5000;

  // Q30 coefficients of sin(pi/4 * a), a in [0,1]
  parameter longint K1 = 64'sd843314857;
  parameter longint K3 = -64'sd86699834;
  parameter longint K5 = 64'sd2674041;
  parameter longint K7 = -64'sd39273;

  // Curve word one, Q1.16
  parameter int CURVE_ONE = 65536;

  // Configuration port
  parameter int ADDR_W = 5;
  parameter int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_PERIOD  = 3'd0,
    REG_MIN     = 3'd1,
    REG_MAX     = 3'd2,
    REG_REVERSE = 3'd3,
    REG_FORWARD = 3'd4,
    REG_COUNT   = 3'd5,
    REG_MASK    = 3'd6
  } reg_idx_e;

  // Register reset values
  parameter logic [12:0] PERIOD_RST  = 13'd2000;
  parameter logic [7:0]  MIN_RST     = 8'd0;
  parameter logic [7:0]  MAX_RST     = 8'd255;
  parameter logic        REVERSE_RST = 1'b0;
  parameter logic        FORWARD_RST = 1'b1;
  parameter logic [3:0]  COUNT_RST   = 4'd8;
  parameter logic [7:0]  MASK_RST    = 8'd255;

  typedef struct packed {
    logic [12:0] period_ms;
    logic [7:0]  min_level;
    logic [7:0]  max_level;
    logic        reverse_phase;
    logic        advance_forward;
    logic [3:0]  led_count;
    logic [7:0]  pwm_mask;
  } blsq_cfg_t;

endpackage

// ===== design/blsq_if.sv =====
`timescale 1ns / 1ps

// Elapsed-time channel
interface blsq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_ms;

  modport source (output valid, output elapsed_ms, input ready);
  modport sink   (input valid, input elapsed_ms, output ready);
endinterface

// LED drive channel
interface blsq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] led_index;
  logic [7:0] level;
  logic       switch_on;
  logic       uses_pwm;
  logic       clear_others;

  modport source (output valid, output led_index, output level, output switch_on,
                  output uses_pwm, output clear_others, input ready);
  modport sink   (input valid, input led_index, input level, input switch_on,
                  input uses_pwm, input clear_others, output ready);
endinterface

// ===== design/blsq_regs.sv =====
`timescale 1ns / 1ps

module blsq_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [blsq_pkg::ADDR_W-1:0]  paddr,
  input  logic [blsq_pkg::DATA_W-1:0]  pwdata,
  output logic [blsq_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output blsq_pkg::blsq_cfg_t          cfg_o
);

  blsq_pkg::blsq_cfg_t cfg_q;
  logic                wr_en;
  logic [2:0]          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];
  assign cfg_o   = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ms       <= blsq_pkg::PERIOD_RST;
      cfg_q.min_level       <= blsq_pkg::MIN_RST;
      cfg_q.max_level       <= blsq_pkg::MAX_RST;
      cfg_q.reverse_phase   <= blsq_pkg::REVERSE_RST;
      cfg_q.advance_forward <= blsq_pkg::FORWARD_RST;
      cfg_q.led_count       <= blsq_pkg::COUNT_RST;
      cfg_q.pwm_mask        <= blsq_pkg::MASK_RST;
    end else if (wr_en) begin
      case (reg_sel)
        blsq_pkg::REG_PERIOD:  cfg_q.period_ms       <= pwdata[12:0];
        blsq_pkg::REG_MIN:     cfg_q.min_level       <= pwdata[7:0];
        blsq_pkg::REG_MAX:     cfg_q.max_level       <= pwdata[7:0];
        blsq_pkg::REG_REVERSE: cfg_q.reverse_phase   <= pwdata[0];
        blsq_pkg::REG_FORWARD: cfg_q.advance_forward <= pwdata[0];
        blsq_pkg::REG_COUNT:   cfg_q.led_count       <= pwdata[3:0];
        blsq_pkg::REG_MASK:    cfg_q.pwm_mask        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_sel)
      blsq_pkg::REG_PERIOD:  prdata = {19'd0, cfg_q.period_ms};
      blsq_pkg::REG_MIN:     prdata = {24'd0, cfg_q.min_level};
      blsq_pkg::REG_MAX:     prdata = {24'd0, cfg_q.max_level};
      blsq_pkg::REG_REVERSE: prdata = {31'd0, cfg_q.reverse_phase};
      blsq_pkg::REG_FORWARD: prdata = {31'd0, cfg_q.advance_forward};
      blsq_pkg::REG_COUNT:   prdata = {28'd0, cfg_q.led_count};
      blsq_pkg::REG_MASK:    prdata = {24'd0, cfg_q.pwm_mask};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== design/blsq_mul.sv =====
`timescale 1ns / 1ps

module blsq_mul (
  input  logic               clk_i,
  input  logic signed [31:0] op_a_i,
  input  logic signed [31:0] op_b_i,
  input  logic               en_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  assign prod_o = prod_q;

  // Register the product of the shared multiplier
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= op_a_i * op_b_i;
    end
  end

endmodule

// ===== design/blsq_seq.sv =====
`timescale 1ns / 1ps

module blsq_seq #(
  parameter int LED_MAX    = blsq_pkg::LED_MAX_DEF,
  parameter int PHASE_BITS = blsq_pkg::PHASE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blsq_pkg::blsq_cfg_t cfg_i,
  blsq_in_if.sink             in_ch,
  blsq_out_if.source          out_ch
);

  localparam int NMAX  = (LED_MAX < 15) ? LED_MAX : 15;
  localparam int ACT_W = (NMAX > 1) ? $clog2(NMAX) : 1;
  localparam int CNT_W = $clog2(PHASE_BITS);
  localparam int ASH   = 18 - PHASE_BITS;
  localparam logic [3:0]            NCAP    = 4'(NMAX);
  localparam logic [PHASE_BITS-1:0] HALF    = PHASE_BITS'(1 << (PHASE_BITS - 1));
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1 << (PHASE_BITS - 2));
  localparam logic [CNT_W-1:0]      CNT_TOP = CNT_W'(PHASE_BITS - 1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_DIV   = 16'b0000_0000_0000_0010,
    S_FOLD  = 16'b0000_0000_0000_0100,
    S_SQA   = 16'b0000_0000_0000_1000,
    S_K7    = 16'b0000_0000_0001_0000,
    S_ACC5  = 16'b0000_0000_0010_0000,
    S_MUL5  = 16'b0000_0000_0100_0000,
    S_ACC3  = 16'b0000_0000_1000_0000,
    S_MUL3  = 16'b0000_0001_0000_0000,
    S_ACC1  = 16'b0000_0010_0000_0000,
    S_MULA  = 16'b0000_0100_0000_0000,
    S_SVAL  = 16'b0000_1000_0000_0000,
    S_MULS  = 16'b0001_0000_0000_0000,
    S_WORD  = 16'b0010_0000_0000_0000,
    S_MULL  = 16'b0100_0000_0000_0000,
    S_LEVEL = 16'b1000_0000_0000_0000
  } state_e;

  // Signed division by 65536 rounding toward zero
  function automatic logic signed [63:0] tdiv16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x >>> 16;
    if (x[63] && (x[15:0] != 16'd0)) begin
      t = t + 64'sd1;
    end
    return t;
  endfunction

  state_e state_q, state_d;

  // Architectural state
  logic [8:0]       accum_q, accum_d;
  logic [12:0]      phase_q, phase_d;
  logic [ACT_W-1:0] active_q, active_d;

  // Working registers
  logic [12:0]            per_q, per_d;
  logic [7:0]             lo_q, lo_d;
  logic [7:0]             hi_q, hi_d;
  logic [12:0]            rem_q, rem_d;
  logic [PHASE_BITS-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   wrap_q, wrap_d;
  logic                   flip_q, flip_d;
  logic [16:0]            arg_q, arg_d;
  logic [16:0]            a2_q, a2_d;
  logic signed [31:0]     p_q, p_d;
  logic [30:0]            s_q, s_d;
  logic [16:0]            word_q, word_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [2:0] out_idx_q, out_idx_d;
  logic [7:0] out_level_q, out_level_d;
  logic       out_on_q, out_on_d;
  logic       out_pwm_q, out_pwm_d;
  logic       out_clr_q, out_clr_d;

  // Shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic               mul_en;
  logic signed [63:0] prod;

  blsq_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .en_i   (mul_en),
    .prod_o (prod)
  );

  // Step logic signals
  logic              in_xfer;
  logic [3:0]        n_led;
  logic [8:0]        sum;
  logic [12:0]       per_c, cc;
  logic [13:0]       fwd_sum;
  logic [3:0]        act4, act_cur, act_new;
  logic [13:0]       rem2;
  logic              div_ge;
  logic [PHASE_BITS-1:0] u_val, q_neg, arg_f;
  logic signed [63:0] t_val;
  logic [18:0]       sq;
  logic [16:0]       word_v;
  logic [8:0]        lvl_sum;
  logic [8:0]        mid;
  logic [3:0]        act_out;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;

  assign out_ch.valid        = out_valid_q;
  assign out_ch.led_index    = out_idx_q;
  assign out_ch.level        = out_level_q;
  assign out_ch.switch_on    = out_on_q;
  assign out_ch.uses_pwm     = out_pwm_q;
  assign out_ch.clear_others = out_clr_q;

  always_comb begin
    // Hold by default
    state_d     = state_q;
    accum_d     = accum_q;
    phase_d     = phase_q;
    active_d    = active_q;
    per_d       = per_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    wrap_d      = wrap_q;
    flip_d      = flip_q;
    arg_d       = arg_q;
    a2_d        = a2_q;
    p_d         = p_q;
    s_d         = s_q;
    word_d      = word_q;
    out_valid_d = out_valid_q & ~out_ch.ready;
    out_idx_d   = out_idx_q;
    out_level_d = out_level_q;
    out_on_d    = out_on_q;
    out_pwm_d   = out_pwm_q;
    out_clr_d   = out_clr_q;
    mul_a       = '0;
    mul_b       = '0;
    mul_en      = 1'b0;

    // Strip size and step arithmetic
    n_led   = (cfg_i.led_count > NCAP) ? NCAP : cfg_i.led_count;
    sum     = accum_q + 9'(in_ch.elapsed_ms);
    per_c   = (cfg_i.period_ms < 13'(blsq_pkg::PERIOD_LO)) ? 13'(blsq_pkg::PERIOD_LO) :
              (cfg_i.period_ms > 13'(blsq_pkg::PERIOD_HI)) ? 13'(blsq_pkg::PERIOD_HI) :
              cfg_i.period_ms;
    cc      = (phase_q > per_c) ? per_c : phase_q;
    fwd_sum = {1'b0, phase_q} + 14'(blsq_pkg::STEP_MS);
    act4    = 4'(active_q);
    act_cur = (act4 >= n_led) ? 4'd0 : act4;
    act_new = act_cur;

    // Divider step
    rem2   = {rem_q, 1'b0};
    div_ge = (rem2 >= {1'b0, per_q});

    // Fold the phase index onto the first quarter
    q_neg = '0 - quo_q;
    u_val = (quo_q <= HALF) ? quo_q : q_neg;
    arg_f = (u_val <= QUARTER) ? u_val : (HALF - u_val);

    t_val   = tdiv16(prod);
    sq      = prod[62:44];
    word_v  = flip_q ? 17'(blsq_pkg::CURVE_ONE - int'(sq)) : sq[16:0];
    lvl_sum = {1'b0, lo_q} + prod[24:16];
    mid     = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
    act_out = 4'(active_q);

    case (state_q)
      S_IDLE: begin
        if (in_xfer && (n_led != 4'd0)) begin
          if (sum < 9'(blsq_pkg::STEP_MS)) begin
            accum_d = sum;
          end else begin
            accum_d = '0;
            per_d   = per_c;
            lo_d    = cfg_i.min_level;
            hi_d    = (cfg_i.max_level < cfg_i.min_level) ? cfg_i.min_level
                                                          : cfg_i.max_level;
            // Step the phase counter
            if (cfg_i.reverse_phase) begin
              if (cc < 13'(blsq_pkg::STEP_MS)) begin
                phase_d = cc + per_c - 13'(blsq_pkg::STEP_MS);
                wrap_d  = 1'b1;
              end else begin
                phase_d = cc - 13'(blsq_pkg::STEP_MS);
                wrap_d  = 1'b0;
              end
            end else begin
              if (fwd_sum >= {1'b0, per_c}) begin
                phase_d = '0;
                wrap_d  = 1'b1;
              end else begin
                phase_d = fwd_sum[12:0];
                wrap_d  = 1'b0;
              end
            end
            // Move the active LED on a wrap
            if (wrap_d) begin
              if (cfg_i.advance_forward) begin
                act_new = (act_cur + 4'd1 == n_led) ? 4'd0 : act_cur + 4'd1;
              end else begin
                act_new = (act_cur == 4'd0) ? n_led - 4'd1 : act_cur - 4'd1;
              end
            end
            active_d = ACT_W'(act_new);
            rem_d    = phase_d;
            quo_d    = '0;
            cnt_d    = CNT_TOP;
            state_d  = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d = div_ge ? 13'(rem2 - {1'b0, per_q}) : rem2[12:0];
        quo_d = {quo_q[PHASE_BITS-2:0], div_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        flip_d  = (u_val > QUARTER);
        arg_d   = 17'(arg_f) << ASH;
        state_d = S_SQA;
      end
      S_SQA: begin
        mul_a   = 32'(arg_q);
        mul_b   = 32'(arg_q);
        mul_en  = 1'b1;
        state_d = S_K7;
      end
      S_K7: begin
        a2_d    = prod[32:16];
        mul_a   = 32'(blsq_pkg::K7);
        mul_b   = 32'(prod[32:16]);
        mul_en  = 1'b1;
        state_d = S_ACC5;
      end
      S_ACC5: begin
        p_d     = 32'(blsq_pkg::K5 + t_val);
        state_d = S_MUL5;
      end
      S_MUL5: begin
        mul_a   = p_q;
        mul_b   = 32'(a2_q);
        mul_en  = 1'b1;
        state_d = S_ACC3;
      end
      S_ACC3: begin
        p_d     = 32'(blsq_pkg::K3 + t_val);
        state_d = S_MUL3;
      end
      S_MUL3: begin
        mul_a   = p_q;
        mul_b   = 32'(a2_q);
        mul_en  = 1'b1;
        state_d = S_ACC1;
      end
      S_ACC1: begin
        p_d     = 32'(blsq_pkg::K1 + t_val);
        state_d = S_MULA;
      end
      S_MULA: begin
        mul_a   = p_q;
        mul_b   = 32'(arg_q);
        mul_en  = 1'b1;
        state_d = S_SVAL;
      end
      S_SVAL: begin
        // Clamp the sine term at zero
        s_d     = t_val[63] ? '0 : t_val[30:0];
        state_d = S_MULS;
      end
      S_MULS: begin
        mul_a   = 32'(s_q);
        mul_b   = 32'(s_q);
        mul_en  = 1'b1;
        state_d = S_WORD;
      end
      S_WORD: begin
        word_d  = word_v;
        state_d = S_MULL;
      end
      S_MULL: begin
        mul_a   = 32'(hi_q - lo_q);
        mul_b   = 32'(word_q);
        mul_en  = 1'b1;
        state_d = S_LEVEL;
      end
      S_LEVEL: begin
        // Load the result once the output register is free
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = act_out[2:0];
          out_level_d = lvl_sum[7:0];
          out_on_d    = ({1'b0, lvl_sum[7:0]} > mid);
          out_pwm_d   = ~act_out[3] & cfg_i.pwm_mask[act_out[2:0]];
          out_clr_d   = wrap_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      accum_q     <= '0;
      phase_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      accum_q     <= accum_d;
      phase_q     <= phase_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and payload
  always_ff @(posedge clk_i) begin
    per_q       <= per_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    wrap_q      <= wrap_d;
    flip_q      <= flip_d;
    arg_q       <= arg_d;
    a2_q        <= a2_d;
    p_q         <= p_d;
    s_q         <= s_d;
    word_q      <= word_d;
    out_idx_q   <= out_idx_d;
    out_level_q <= out_level_d;
    out_on_q    <= out_on_d;
    out_pwm_q   <= out_pwm_d;
    out_clr_q   <= out_clr_d;
  end

endmodule

// ===== design/breathing_led_sequencer.sv =====
`timescale 1ns / 1ps

// Breathing LED sequencer. Each transfer on in_ch reports elapsed milliseconds;
// once 20 ms have gathered the block steps its phase counter by 20 within the
// breathing period, works out a raised-cosine brightness between min_level and
// max_level, moves the active LED on a phase wrap, and sends one transfer on
// out_ch for the active LED. An item that does not complete a 20 ms step is
// taken and gives no result. An item that does is processed by the restoring
// divider for the phase index (one quotient bit a cycle) followed by seven
// passes through one shared 32x32 multiplier for the curve polynomial and
// level scaling; in_ch is not ready meanwhile. A finished result waits in an
// output register, so the next item may start before out_ch takes it.
// Registers must be written over the APB port only while the block is idle;
// the block itself does not enforce this.
module breathing_led_sequencer #(
  parameter int LED_MAX    = blsq_pkg::LED_MAX_DEF,
  parameter int PHASE_BITS = blsq_pkg::PHASE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  blsq_in_if.sink                     in_ch,
  blsq_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [blsq_pkg::ADDR_W-1:0] paddr,
  input  logic [blsq_pkg::DATA_W-1:0] pwdata,
  output logic [blsq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  blsq_pkg::blsq_cfg_t cfg;

  // Configuration registers
  blsq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Step sequencer with shared arithmetic
  blsq_seq #(
    .LED_MAX    (LED_MAX),
    .PHASE_BITS (PHASE_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
